### src/cpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cpa_pkg;

    localparam int CORDIC_STAGES = 24;

    localparam logic [2:0] OP_FROM_RECT  = 3'd0;
    localparam logic [2:0] OP_FROM_POLAR = 3'd1;
    localparam logic [2:0] OP_ADD        = 3'd2;
    localparam logic [2:0] OP_SUB        = 3'd3;
    localparam logic [2:0] OP_MUL        = 3'd4;
    localparam logic [2:0] OP_DIV        = 3'd5;

    localparam logic signed [33:0] PI_Q      = 34'sd1686629713;
    localparam logic signed [33:0] TAU_Q     = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q = 34'sd843314857;
    localparam logic [29:0]        GAIN_Q30  = 30'd652032874;
    localparam logic [30:0]        RAD_MAX   = 31'h7FFFFFFF;

    localparam logic [28:0] ATAN_Q29 [32] = '{
        29'd421657428, 29'd248918915, 29'd131521918, 29'd66762579, 29'd33510843,
        29'd16771758, 29'd8387925, 29'd4194219, 29'd2097141, 29'd1048575,
        29'd524288, 29'd262144, 29'd131072, 29'd65536, 29'd32768, 29'd16384,
        29'd8192, 29'd4096, 29'd2048, 29'd1024, 29'd512, 29'd256, 29'd128,
        29'd64, 29'd32, 29'd16, 29'd8, 29'd4, 29'd2, 29'd1, 29'd0, 29'd0
    };

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] a_real;
        logic signed [31:0] a_imag;
        logic [30:0]        a_rad;
        logic signed [31:0] a_theta;
        logic signed [31:0] b_real;
        logic signed [31:0] b_imag;
        logic [30:0]        b_rad;
        logic signed [31:0] b_theta;
    } req_t;

    typedef struct packed {
        logic signed [31:0] res_real;
        logic signed [31:0] res_imag;
        logic [30:0]        res_rad;
        logic signed [31:0] res_theta;
        logic               div_by_zero;
    } rsp_t;

endpackage

`default_nettype wire

### src/complex_polar_arith_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Complex arithmetic on rectangular and polar values (Q16.16 parts, Q2.29 angle).
// Fully pipelined: one word enters per cycle while the pipeline is not held, and every
// word passes through two input stages, the 33-stage square root and divider recurrence
// (a load stage, then one root bit per stage and one quotient bit in each of the first
// 31 of them), three setup stages, the CORDIC stages, one rotation per stage, and the
// output register. A response not taken holds the whole pipeline, so req_ready follows
// rsp_ready while rsp_valid is high.
module complex_polar_arith_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire cpa_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output cpa_pkg::rsp_t      rsp
);
    import cpa_pkg::*;

    localparam int N = CORDIC_STAGES;

    typedef enum logic [1:0] {K_VEC, K_ROT, K_ZERO} kind_t;

    typedef struct packed {
        kind_t              kind;
        logic               is_mul;
        logic               is_div;
        logic               divz;
        logic               neg;
        logic               spec;
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic signed [31:0] theta;
        logic [30:0]        rad;
    } carry_t;

    typedef struct packed {
        logic [63:0] n;
        logic [31:0] root;
        logic [35:0] srem;
        logic [31:0] drem;
        logic [30:0] dlow;
        logic [30:0] brad;
        logic [30:0] q;
        logic        dovf;
    } rec_t;

    typedef struct packed {
        logic signed [51:0] x;
        logic signed [51:0] y;
        logic signed [33:0] z;
    } cord_t;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -36'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] wrap_once(input logic signed [33:0] t);
        logic signed [33:0] r;
        if (t > PI_Q)
            r = t - TAU_Q;
        else if (t < -PI_Q)
            r = t + TAU_Q;
        else
            r = t;
        return r[31:0];
    endfunction

    logic adv;
    assign adv       = !rsp_valid || rsp_ready;
    assign req_ready = adv;

    // input stage
    logic        s1_vld_reg;
    carry_t      s1_c_reg, s1_c_next;
    logic [61:0] s1_prod_reg, s1_prod_next;
    logic [47:0] s1_num_reg, s1_num_next;
    logic [30:0] s1_brad_reg;
    logic signed [32:0] sum_r, sum_i, dif_r, dif_i;

    always_comb
    begin
        sum_r = {req.a_real[31], req.a_real} + {req.b_real[31], req.b_real};
        sum_i = {req.a_imag[31], req.a_imag} + {req.b_imag[31], req.b_imag};
        dif_r = {req.a_real[31], req.a_real} - {req.b_real[31], req.b_real};
        dif_i = {req.a_imag[31], req.a_imag} - {req.b_imag[31], req.b_imag};
        s1_prod_next = req.a_rad * req.b_rad;
        s1_num_next  = {1'b0, req.a_rad, 16'b0} + {18'b0, req.b_rad[30:1]};
        s1_c_next    = '0;
        s1_c_next.kind = K_ZERO;
        unique case (req.operation)
            OP_FROM_RECT:
            begin
                s1_c_next.kind = K_VEC;
                s1_c_next.re   = req.a_real;
                s1_c_next.im   = req.a_imag;
            end
            OP_FROM_POLAR:
            begin
                s1_c_next.kind  = K_ROT;
                s1_c_next.rad   = req.a_rad;
                s1_c_next.theta = wrap_once(34'(req.a_theta));
            end
            OP_ADD:
            begin
                s1_c_next.kind = K_VEC;
                s1_c_next.re   = sat32(36'(sum_r));
                s1_c_next.im   = sat32(36'(sum_i));
            end
            OP_SUB:
            begin
                s1_c_next.kind = K_VEC;
                s1_c_next.re   = sat32(36'(dif_r));
                s1_c_next.im   = sat32(36'(dif_i));
            end
            OP_MUL:
            begin
                s1_c_next.kind   = K_ROT;
                s1_c_next.is_mul = 1'b1;
                s1_c_next.theta  = wrap_once(34'(req.a_theta) + 34'(req.b_theta));
            end
            OP_DIV:
            begin
                if (req.b_rad == '0)
                    s1_c_next.divz = 1'b1;
                else
                begin
                    s1_c_next.kind   = K_ROT;
                    s1_c_next.is_div = 1'b1;
                    s1_c_next.theta  = wrap_once(34'(req.a_theta) - 34'(req.b_theta));
                end
            end
            default:
            begin
                s1_c_next.kind = K_ZERO;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (adv)
            s1_vld_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_c_reg    <= s1_c_next;
            s1_prod_reg <= s1_prod_next;
            s1_num_reg  <= s1_num_next;
            s1_brad_reg <= req.b_rad;
        end
    end

    // squares and product rounding
    logic               s2_vld_reg;
    carry_t             s2_c_reg, s2_c_next;
    logic signed [63:0] s2_sqr_reg, s2_sqi_reg;
    logic [47:0]        s2_num_reg;
    logic [30:0]        s2_brad_reg;
    logic [62:0]        mul_rnd;

    always_comb
    begin
        mul_rnd   = {1'b0, s1_prod_reg} + 63'd32768;
        s2_c_next = s1_c_reg;
        if (s1_c_reg.is_mul)
            s2_c_next.rad = (|mul_rnd[62:47]) ? RAD_MAX : mul_rnd[46:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (adv)
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_c_reg    <= s2_c_next;
            s2_sqr_reg  <= s1_c_reg.re * s1_c_reg.re;
            s2_sqi_reg  <= s1_c_reg.im * s1_c_reg.im;
            s2_num_reg  <= s1_num_reg;
            s2_brad_reg <= s1_brad_reg;
        end
    end

    // square root and divide recurrence
    logic [32:0] rec_vld_reg;
    rec_t        rec_reg [33];
    rec_t        rec_next [33];
    carry_t      rec_c_reg [33];

    always_comb
    begin
        rec_next[0]      = '0;
        rec_next[0].n    = s2_sqr_reg[63:0] + s2_sqi_reg[63:0];
        rec_next[0].drem = {15'b0, s2_num_reg[47:31]};
        rec_next[0].dlow = s2_num_reg[30:0];
        rec_next[0].brad = s2_brad_reg;
        rec_next[0].dovf = {14'b0, s2_num_reg[47:31]} >= s2_brad_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rec_vld_reg[0] <= 1'b0;
        else if (adv)
            rec_vld_reg[0] <= s2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rec_reg[0]   <= rec_next[0];
            rec_c_reg[0] <= s2_c_reg;
        end
    end

    for (genvar k = 0; k < 32; k++)
    begin : g_rec
        logic [35:0] sh;
        logic [35:0] trial;
        logic [31:0] dt;

        always_comb
        begin
            rec_next[k+1] = rec_reg[k];
            sh    = {rec_reg[k].srem[33:0], rec_reg[k].n[63-2*k -: 2]};
            trial = {2'b0, rec_reg[k].root, 2'b01};
            if (sh >= trial)
            begin
                rec_next[k+1].srem = sh - trial;
                rec_next[k+1].root = {rec_reg[k].root[30:0], 1'b1};
            end
            else
            begin
                rec_next[k+1].srem = sh;
                rec_next[k+1].root = {rec_reg[k].root[30:0], 1'b0};
            end
            dt = '0;
            if (k < 31)
            begin
                dt = {rec_reg[k].drem[30:0], rec_reg[k].dlow[30 - (k % 31)]};
                if (dt >= {1'b0, rec_reg[k].brad})
                begin
                    rec_next[k+1].drem = dt - {1'b0, rec_reg[k].brad};
                    rec_next[k+1].q    = {rec_reg[k].q[29:0], 1'b1};
                end
                else
                begin
                    rec_next[k+1].drem = dt;
                    rec_next[k+1].q    = {rec_reg[k].q[29:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rec_vld_reg[k+1] <= 1'b0;
            else if (adv)
                rec_vld_reg[k+1] <= rec_vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rec_reg[k+1]   <= rec_next[k+1];
                rec_c_reg[k+1] <= rec_c_reg[k];
            end
        end
    end

    // radius select
    logic        p1_vld_reg;
    carry_t      p1_c_reg, p1_c_next;
    logic [32:0] rect_rad;

    always_comb
    begin
        rect_rad  = {1'b0, rec_reg[32].root}
                  + {32'b0, (rec_reg[32].srem > {4'b0, rec_reg[32].root})};
        p1_c_next = rec_c_reg[32];
        if (rec_c_reg[32].kind == K_VEC)
            p1_c_next.rad = (|rect_rad[32:31]) ? RAD_MAX : rect_rad[30:0];
        else if (rec_c_reg[32].is_div)
            p1_c_next.rad = rec_reg[32].dovf ? RAD_MAX : rec_reg[32].q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_vld_reg <= 1'b0;
        else if (adv)
            p1_vld_reg <= rec_vld_reg[32];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            p1_c_reg <= p1_c_next;
    end

    // gain multiply, quadrant fold, axis cases
    logic               p2_vld_reg;
    carry_t             p2_c_reg, p2_c_next;
    logic [60:0]        p2_gprod_reg;
    logic signed [33:0] p2_z_reg, p2_z_next;
    logic signed [33:0] th;

    always_comb
    begin
        th        = 34'(p1_c_reg.theta);
        p2_c_next = p1_c_reg;
        p2_z_next = th;
        if (th > HALF_PI_Q)
        begin
            p2_z_next     = th - PI_Q;
            p2_c_next.neg = 1'b1;
        end
        else if (th < -HALF_PI_Q)
        begin
            p2_z_next     = th + PI_Q;
            p2_c_next.neg = 1'b1;
        end
        if (p1_c_reg.kind == K_VEC)
        begin
            if (p1_c_reg.im == '0)
            begin
                p2_c_next.spec  = 1'b1;
                p2_c_next.theta = p1_c_reg.re[31] ? PI_Q[31:0] : '0;
            end
            else if (p1_c_reg.re == '0)
            begin
                p2_c_next.spec  = 1'b1;
                p2_c_next.theta = p1_c_reg.im[31] ? 32'(-HALF_PI_Q) : HALF_PI_Q[31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_vld_reg <= 1'b0;
        else if (adv)
            p2_vld_reg <= p1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_c_reg     <= p2_c_next;
            p2_gprod_reg <= p1_c_reg.rad * GAIN_Q30;
            p2_z_reg     <= p2_z_next;
        end
    end

    // cordic
    logic [N:0] cord_vld_reg;
    cord_t      cord_reg [N+1];
    cord_t      cord_next [N+1];
    carry_t     cord_c_reg [N+1];
    logic [60:0]        gp_rnd;
    logic signed [51:0] vx, vy;

    always_comb
    begin
        gp_rnd = p2_gprod_reg + 61'd8192;
        vx = {{4{p2_c_reg.re[31]}}, p2_c_reg.re, 16'b0};
        vy = {{4{p2_c_reg.im[31]}}, p2_c_reg.im, 16'b0};
        if (p2_c_reg.kind == K_VEC)
        begin
            if (p2_c_reg.re[31])
            begin
                cord_next[0].x = -vx;
                cord_next[0].y = -vy;
                cord_next[0].z = p2_c_reg.im[31] ? -PI_Q : PI_Q;
            end
            else
            begin
                cord_next[0].x = vx;
                cord_next[0].y = vy;
                cord_next[0].z = '0;
            end
        end
        else
        begin
            cord_next[0].x = {5'b0, gp_rnd[60:14]};
            cord_next[0].y = '0;
            cord_next[0].z = p2_z_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cord_vld_reg[0] <= 1'b0;
        else if (adv)
            cord_vld_reg[0] <= p2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cord_reg[0]   <= cord_next[0];
            cord_c_reg[0] <= p2_c_reg;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_cord
        logic signed [51:0] dx, dy;
        logic signed [33:0] ang;
        logic               d;

        always_comb
        begin
            dx  = cord_reg[i].x >>> i;
            dy  = cord_reg[i].y >>> i;
            ang = {5'b0, ATAN_Q29[i]};
            d   = (cord_c_reg[i].kind == K_VEC) ? cord_reg[i].y[51] : !cord_reg[i].z[33];
            if (d)
            begin
                cord_next[i+1].x = cord_reg[i].x - dy;
                cord_next[i+1].y = cord_reg[i].y + dx;
                cord_next[i+1].z = cord_reg[i].z - ang;
            end
            else
            begin
                cord_next[i+1].x = cord_reg[i].x + dy;
                cord_next[i+1].y = cord_reg[i].y - dx;
                cord_next[i+1].z = cord_reg[i].z + ang;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cord_vld_reg[i+1] <= 1'b0;
            else if (adv)
                cord_vld_reg[i+1] <= cord_vld_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cord_reg[i+1]   <= cord_next[i+1];
                cord_c_reg[i+1] <= cord_c_reg[i];
            end
        end
    end

    // output word
    logic               rsp_vld_reg;
    rsp_t               rsp_reg, rsp_next;
    carry_t             fc;
    logic signed [51:0] fx, fy;
    logic signed [33:0] fz;

    always_comb
    begin
        fc = cord_c_reg[N];
        fx = (fc.neg ? -cord_reg[N].x : cord_reg[N].x) + 52'sd32768;
        fy = (fc.neg ? -cord_reg[N].y : cord_reg[N].y) + 52'sd32768;
        fz = cord_reg[N].z;
        if (fz > PI_Q)
            fz = PI_Q;
        else if (fz < -PI_Q)
            fz = -PI_Q;
        rsp_next = '0;
        unique case (fc.kind)
            K_VEC:
            begin
                rsp_next.res_real  = fc.re;
                rsp_next.res_imag  = fc.im;
                rsp_next.res_rad   = fc.rad;
                rsp_next.res_theta = fc.spec ? fc.theta : fz[31:0];
            end
            K_ROT:
            begin
                rsp_next.res_real  = sat32(fx[51:16]);
                rsp_next.res_imag  = sat32(fy[51:16]);
                rsp_next.res_rad   = fc.rad;
                rsp_next.res_theta = fc.theta;
            end
            default:
            begin
                rsp_next.div_by_zero = fc.divz;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_vld_reg <= 1'b0;
        else if (adv)
            rsp_vld_reg <= cord_vld_reg[N];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

`ifndef NO_ASSERTIONS
    a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.div_by_zero |-> rsp.res_real == '0 && rsp.res_imag == '0
            && rsp.res_rad == '0 && rsp.res_theta == '0)
        else $error("divide by zero word carries nonzero fields");

    a_theta_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> 34'(rsp.res_theta) <= PI_Q && 34'(rsp.res_theta) >= -PI_Q)
        else $error("result angle outside range");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> s1_vld_reg)
        else $error("accepted word lost at input stage");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(cord_vld_reg) && $stable(rec_vld_reg))
        else $error("pipeline moved during stall");
`endif

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import cpa_pkg::*;

    localparam longint PI_V     = 64'sd1686629713;
    localparam longint TAU_V    = 64'sd3373259426;
    localparam longint HPI_V    = 64'sd843314857;
    localparam longint GAIN_V   = 64'sd652032874;
    localparam longint RMAX_V   = 64'sd2147483647;
    localparam int     LATENCY  = 63;
    localparam int     NSTAGE   = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  req_valid = 1'b0;
    logic  req_ready;
    req_t  req = '0;
    logic  rsp_valid;
    logic  rsp_ready = 1'b0;
    rsp_t  rsp;

    rsp_t  expected_q[$];
    int    mismatches = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    int    hold_off_cycles = 0;

    longint atan_tab [32] = '{
        421657428, 248918915, 131521918, 66762579, 33510843,
        16771758, 8387925, 4194219, 2097141, 1048575,
        524288, 262144, 131072, 65536, 32768, 16384,
        8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0
    };

    complex_polar_arith_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #1 clk = ~clk;

    function automatic longint floor_shift(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -(((-v) - 1) >>> s) - 1;
    endfunction

    function automatic longint sat_s32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint sat_radius(longint v);
        if (v > RMAX_V)
            return RMAX_V;
        if (v < 0)
            return 0;
        return v;
    endfunction

    function automatic longint wrap_angle(longint t);
        if (t > PI_V)
            return t - TAU_V;
        if (t < -PI_V)
            return t + TAU_V;
        return t;
    endfunction

    function automatic longint root_nearest(logic [63:0] n);
        logic [63:0] rem, root, b;
        rem = n;
        root = 0;
        b = 64'd1 << 62;
        while (b > rem)
            b = b >> 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem = rem - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        if (rem > root)
            root = root + 1;
        return longint'(root);
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z, off, dx, dy;
        z = 0;
        off = 0;
        if (y == 0)
            return (x < 0) ? PI_V : 0;
        if (x == 0)
            return (y > 0) ? HPI_V : -HPI_V;
        x = x * 65536;
        y = y * 65536;
        if (x < 0) begin
            off = (y >= 0) ? PI_V : -PI_V;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < NSTAGE; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += atan_tab[i];
            end else begin
                x -= dx; y += dy; z -= atan_tab[i];
            end
        end
        z = off + z;
        if (z > PI_V)
            z = PI_V;
        if (z < -PI_V)
            z = -PI_V;
        return z;
    endfunction

    function automatic rsp_t rect_value(longint re, longint im);
        rsp_t r;
        logic [63:0] sq;
        sq = 64'(re * re) + 64'(im * im);
        r = '0;
        r.res_real = re[31:0];
        r.res_imag = im[31:0];
        r.res_rad = 31'(sat_radius(root_nearest(sq)));
        r.res_theta = 32'(vector_angle(im, re));
        return r;
    endfunction

    function automatic rsp_t polar_value(longint rad, longint theta);
        rsp_t r;
        longint x, y, z, dx, dy;
        bit neg;
        x = floor_shift(rad * GAIN_V + (64'sd1 << 13), 14);
        y = 0;
        z = theta;
        neg = 0;
        if (z > HPI_V) begin
            z -= PI_V; neg = 1;
        end else if (z < -HPI_V) begin
            z += PI_V; neg = 1;
        end
        for (int i = 0; i < NSTAGE; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        if (neg) begin
            x = -x; y = -y;
        end
        r = '0;
        r.res_real = 32'(sat_s32(floor_shift(x + 32768, 16)));
        r.res_imag = 32'(sat_s32(floor_shift(y + 32768, 16)));
        r.res_rad = 31'(rad);
        r.res_theta = 32'(theta);
        return r;
    endfunction

    function automatic rsp_t complex_result(req_t w);
        longint ar, ai, br, bi, ara, bra, ath, bth, q;
        rsp_t r;
        ar = w.a_real; ai = w.a_imag; br = w.b_real; bi = w.b_imag;
        ara = longint'({1'b0, w.a_rad}); bra = longint'({1'b0, w.b_rad});
        ath = w.a_theta; bth = w.b_theta;
        r = '0;
        case (w.operation)
            OP_FROM_RECT:  r = rect_value(ar, ai);
            OP_FROM_POLAR: r = polar_value(ara, wrap_angle(ath));
            OP_ADD:        r = rect_value(sat_s32(ar + br), sat_s32(ai + bi));
            OP_SUB:        r = rect_value(sat_s32(ar - br), sat_s32(ai - bi));
            OP_MUL:        r = polar_value(sat_radius((ara * bra + 32768) >>> 16),
                                           wrap_angle(ath + bth));
            OP_DIV: begin
                if (bra == 0) begin
                    r.div_by_zero = 1'b1;
                end else begin
                    q = ((ara << 16) + (bra >> 1)) / bra;
                    r = polar_value(sat_radius(q), wrap_angle(ath - bth));
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    // valid stays high after a word until the next word or an idle cycle
    task automatic send_word(req_t w);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        expected_q.push_back(complex_result(w));
        @(negedge clk);
    endtask

    // receiver side
    always @(negedge clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_ready <= 1'b0;
        end else begin
            rsp_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        rsp_t e;
        if (rst_n && rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %h", rsp);
            end else begin
                e = expected_q.pop_front();
                if (rsp !== e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp re %h im %h rad %h th %h dz %b / got %h %h %h %h %b",
                            e.res_real, e.res_imag, e.res_rad, e.res_theta, e.div_by_zero,
                            rsp.res_real, rsp.res_imag, rsp.res_rad, rsp.res_theta,
                            rsp.div_by_zero);
                end
            end
        end
    end

    function automatic logic [31:0] rand_part();
        case ($urandom_range(5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'($urandom_range(8)) - 32'd4;
            3: return 32'(int'($urandom_range(2000000)) - 1000000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] rand_radius();
        case ($urandom_range(4))
            0: return 31'h7FFFFFFF;
            1: return 31'($urandom_range(3));
            2: return 31'($urandom_range(1 << 20));
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_angle();
        case ($urandom_range(4))
            0: return 32'(PI_V);
            1: return 32'(-PI_V);
            2: return 32'($urandom_range(2));
            default: return 32'(longint'($urandom_range(32'd3373259426)) - PI_V);
        endcase
    endfunction

    function automatic req_t rand_word();
        req_t w;
        w.operation = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6))
                                                 : 3'($urandom_range(5));
        w.a_real = rand_part();
        w.a_imag = rand_part();
        w.a_rad = rand_radius();
        w.a_theta = rand_angle();
        w.b_real = rand_part();
        w.b_imag = rand_part();
        w.b_rad = rand_radius();
        w.b_theta = rand_angle();
        return w;
    endfunction

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic mk_send(logic [2:0] op, logic [31:0] ar, logic [31:0] ai,
                           logic [30:0] ara, logic [31:0] ath, logic [31:0] br,
                           logic [31:0] bi, logic [30:0] bra, logic [31:0] bth);
        req_t w;
        w = '{op, ar, ai, ara, ath, br, bi, bra, bth};
        send_word(w);
    endtask

    task automatic test_directed();
        mk_send(OP_FROM_RECT, 0, 0, 0, 0, 0, 0, 0, 0);
        mk_send(OP_FROM_RECT, 32'h00010000, 0, 0, 0, 0, 0, 0, 0);
        mk_send(OP_FROM_RECT, 32'hFFFF0000, 0, 0, 0, 0, 0, 0, 0);
        mk_send(OP_FROM_RECT, 0, 32'h00030000, 0, 0, 0, 0, 0, 0);
        mk_send(OP_FROM_RECT, 0, 32'h80000000, 0, 0, 0, 0, 0, 0);
        mk_send(OP_FROM_RECT, 32'h80000000, 32'h80000000, 0, 0, 0, 0, 0, 0);
        mk_send(OP_FROM_RECT, 32'h7FFFFFFF, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0);
        mk_send(OP_FROM_POLAR, 0, 0, 31'h7FFFFFFF, 32'(PI_V), 0, 0, 0, 0);
        mk_send(OP_FROM_POLAR, 0, 0, 31'h00010000, 32'(-PI_V), 0, 0, 0, 0);
        mk_send(OP_FROM_POLAR, 0, 0, 31'h00020000, 32'(HPI_V), 0, 0, 0, 0);
        mk_send(OP_FROM_POLAR, 0, 0, 31'h00020000, 32'h80000000, 0, 0, 0, 0);
        mk_send(OP_FROM_POLAR, 0, 0, 31'h00020000, 32'h7FFFFFFF, 0, 0, 0, 0);
        mk_send(OP_ADD, 32'h7FFFFFFF, 32'h80000000, 0, 0, 1, 32'hFFFFFFFF, 0, 0);
        mk_send(OP_ADD, 32'h00010000, 32'h00010000, 0, 0, 32'h00020000, 0, 0, 0);
        mk_send(OP_SUB, 32'h80000000, 32'h7FFFFFFF, 0, 0, 1, 32'hFFFFFFFF, 0, 0);
        mk_send(OP_SUB, 5, 7, 0, 0, 5, 7, 0, 0);
        mk_send(OP_MUL, 0, 0, 31'h7FFFFFFF, 32'(PI_V), 0, 0, 31'h7FFFFFFF, 32'(PI_V));
        mk_send(OP_MUL, 0, 0, 31'h00018000, 32'(-PI_V), 0, 0, 31'h00008000, 32'(-PI_V));
        mk_send(OP_DIV, 0, 0, 31'h00010000, 0, 0, 0, 0, 0);
        mk_send(OP_DIV, 0, 0, 31'h7FFFFFFF, 32'(PI_V), 0, 0, 1, 32'(-PI_V));
        mk_send(OP_DIV, 0, 0, 31'h00030000, 32'(-PI_V), 0, 0, 31'h00020000, 32'(PI_V));
        mk_send(3'd6, '1, '1, '1, '1, '1, '1, '1, '1);
        mk_send(3'd7, '1, '1, '1, '1, '1, '1, '1, '1);
        wait_drained();
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            send_word(rand_word());
        wait_drained();
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        @(negedge clk);
        hold_off_cycles = 300;
        repeat (150)
            send_word(rand_word());
        wait_drained();
    endtask

    initial begin
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(90, 0, 0);
        test_random(90, 71, 0);
        test_random(90, 0, 71);
        test_random(90, 38, 38);
        test_backpressure();
        wait_drained();
        repeat (LATENCY + 10)
            @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #400000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
